@@ design/chc_pkg.sv @@
// Shared types and constants for the chunk I/O heat classifier.
package chc_pkg;

  // Field and register widths
  localparam int SECTOR_W    = 32;
  localparam int OUT_COUNT_W = 32;
  localparam int SHIFT_W     = 5;
  localparam int CHUNKS_W    = 11;
  localparam int RATIO_W     = 8;
  localparam int HOT_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int MODE_W      = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SHIFT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_IN_USE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOMINANCE_RATIO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_LEVEL       = 2'd3;

  // Configuration reset values
  localparam logic [SHIFT_W-1:0]  RST_CHUNK_SHIFT     = 5'd11;
  localparam logic [CHUNKS_W-1:0] RST_CHUNKS_IN_USE   = 11'd1024;
  localparam logic [RATIO_W-1:0]  RST_DOMINANCE_RATIO = 8'd10;
  localparam logic [HOT_W-1:0]    RST_HOT_LEVEL       = 16'd100;

  // Function codes
  localparam logic FUNC_ACCOUNT = 1'b0;
  localparam logic FUNC_QUERY   = 1'b1;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_READ_HOT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE_HOT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BOTH_HOT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BOTH_COLD = 2'd3;

  // Control fields of one queued item
  typedef struct packed {
    logic func;
    logic is_write;
    logic oor;
  } qctl_t;

  // Configuration the back end needs
  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [HOT_W-1:0]   hot_level;
  } cfg_regs_t;

endpackage

@@ design/chc_front.sv @@
// Front end: configuration registers, chunk index and range check, queue push.
module chc_front
  import chc_pkg::*;
#(
  parameter int MAX_CHUNKS = 1024,
  parameter int IDX_W      = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_func,
  input  logic [SECTOR_W-1:0]   in_sector,
  input  logic                  in_is_write,
  output logic                  in_stall,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  cfg_ready,
  input  logic                  q_full,
  input  logic                  clear_done,
  output logic                  push,
  output qctl_t                 push_ctl,
  output logic [IDX_W-1:0]      push_idx,
  output cfg_regs_t             cfg
);

  logic [SHIFT_W-1:0]  shift_r;
  logic [CHUNKS_W-1:0] chunks_r;
  logic [RATIO_W-1:0]  ratio_r;
  logic [HOT_W-1:0]    hot_r;
  logic [SECTOR_W-1:0] idx_full;
  logic                in_range;

  assign cfg_ready = 1'b1;

  // Update configuration registers on a write transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r  <= RST_CHUNK_SHIFT;
      chunks_r <= RST_CHUNKS_IN_USE;
      ratio_r  <= RST_DOMINANCE_RATIO;
      hot_r    <= RST_HOT_LEVEL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CHUNK_SHIFT:     shift_r  <= cfg_data[SHIFT_W-1:0];
        CFG_CHUNKS_IN_USE:   chunks_r <= cfg_data[CHUNKS_W-1:0];
        CFG_DOMINANCE_RATIO: ratio_r  <= cfg_data[RATIO_W-1:0];
        CFG_HOT_LEVEL:       hot_r    <= cfg_data[HOT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.ratio     = ratio_r;
  assign cfg.hot_level = hot_r;

  // Map sector to chunk and check it against the chunks in use
  assign idx_full = in_sector >> shift_r;
  assign in_range = (idx_full < SECTOR_W'(chunks_r)) &&
                    (idx_full < SECTOR_W'(MAX_CHUNKS));

  // Hold off input while the queue is full or the counters are being cleared
  assign in_stall = q_full || !clear_done;
  assign push     = in_valid && !in_stall;

  assign push_ctl.func     = in_func;
  assign push_ctl.is_write = in_is_write;
  assign push_ctl.oor      = !in_range;
  assign push_idx          = idx_full[IDX_W-1:0];

endmodule

@@ design/chc_queue.sv @@
// Two-entry queue between the front end and the back end.
module chc_queue #(
  parameter int W = 13
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         not_empty
);

  logic [W-1:0] ent_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;
  logic [1:0]   cnt_nxt;

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= din;
    end
  end

  // Track pointers and fill level
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign dout      = ent_r[rd_ptr_r];
  assign full      = cnt_r[1];
  assign not_empty = (cnt_r != 2'd0);

endmodule

@@ design/chc_back.sv @@
// Back end: counter memories, clearing pass, update and shift-add classifier.
module chc_back
  import chc_pkg::*;
#(
  parameter int MAX_CHUNKS  = 1024,
  parameter int COUNT_WIDTH = 32,
  parameter int IDX_W       = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  qctl_t                  q_ctl,
  input  logic [IDX_W-1:0]       q_idx,
  output logic                   q_pop,
  input  cfg_regs_t              cfg,
  output logic                   clear_done,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [MODE_W-1:0]      out_mode,
  output logic [OUT_COUNT_W-1:0] out_read_count,
  output logic [OUT_COUNT_W-1:0] out_write_count,
  output logic                   out_out_of_range
);

  localparam int PW = COUNT_WIDTH + RATIO_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CHUNKS - 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_CALC  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_CLASS = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t                 state_r;
  logic [IDX_W-1:0]       idx_r;
  qctl_t                  ctl_r;
  logic [COUNT_WIDTH-1:0] rmem [MAX_CHUNKS];
  logic [COUNT_WIDTH-1:0] wmem [MAX_CHUNKS];
  logic [COUNT_WIDTH-1:0] rd_r;
  logic [COUNT_WIDTH-1:0] wd_r;
  logic [COUNT_WIDTH-1:0] wdata;
  logic                   we_read;
  logic                   we_write;
  logic [PW-1:0]          mr_r;
  logic [PW-1:0]          mw_r;
  logic [PW-1:0]          pr_r;
  logic [PW-1:0]          pw_r;
  logic [RATIO_W-1:0]     ratio_r;
  logic [2:0]             step_r;
  logic [MODE_W-1:0]      mode_r;
  logic [63:0]            rd_ext;
  logic [63:0]            wd_ext;
  logic [OUT_COUNT_W-1:0] ocnt_r_r;
  logic [OUT_COUNT_W-1:0] ocnt_w_r;
  logic                   oor_r;
  logic [MODE_W-1:0]      mode_nxt;

  // Memory write: zero during clearing, saturating increment on an account
  always_comb begin
    we_read  = 1'b0;
    we_write = 1'b0;
    wdata    = '0;
    if (state_r == S_CLEAR) begin
      we_read  = 1'b1;
      we_write = 1'b1;
    end else if (state_r == S_CALC && ctl_r.func == FUNC_ACCOUNT) begin
      if (ctl_r.is_write) begin
        we_write = 1'b1;
        wdata    = (wd_r == '1) ? wd_r : wd_r + COUNT_WIDTH'(1);
      end else begin
        we_read  = 1'b1;
        wdata    = (rd_r == '1) ? rd_r : rd_r + COUNT_WIDTH'(1);
      end
    end
  end

  // Counter memories, read data registered; address is stable while an item runs
  always_ff @(posedge clk) begin
    if (we_read) begin
      rmem[idx_r] <= wdata;
    end
    if (we_write) begin
      wmem[idx_r] <= wdata;
    end
    rd_r <= rmem[idx_r];
    wd_r <= wmem[idx_r];
  end

  // Classify from the finished products
  always_comb begin
    if (PW'(rd_r) >= pw_r) begin
      mode_nxt = MODE_READ_HOT;
    end else if (PW'(wd_r) >= pr_r) begin
      mode_nxt = MODE_WRITE_HOT;
    end else if (PW'(rd_r) > PW'(cfg.hot_level) && PW'(wd_r) > PW'(cfg.hot_level)) begin
      mode_nxt = MODE_BOTH_HOT;
    end else begin
      mode_nxt = MODE_BOTH_COLD;
    end
  end

  assign rd_ext = 64'(rd_r);
  assign wd_ext = 64'(wd_r);

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r   <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          idx_r <= idx_r + IDX_W'(1);
          if (idx_r == LAST_IDX) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            idx_r <= q_idx;
            ctl_r <= q_ctl;
            if (q_ctl.oor) begin
              // drop an account, answer a query as out of range
              if (q_ctl.func == FUNC_QUERY) begin
                mode_r   <= MODE_BOTH_COLD;
                ocnt_r_r <= '0;
                ocnt_w_r <= '0;
                oor_r    <= 1'b1;
                state_r  <= S_OUT;
              end
            end else begin
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          state_r <= S_CALC;
        end
        S_CALC: begin
          if (ctl_r.func == FUNC_ACCOUNT) begin
            state_r <= S_IDLE;
          end else begin
            mr_r    <= PW'(rd_r);
            mw_r    <= PW'(wd_r);
            pr_r    <= '0;
            pw_r    <= '0;
            ratio_r <= cfg.ratio;
            step_r  <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          // one ratio bit per cycle into both products
          if (ratio_r[0]) begin
            pr_r <= pr_r + mr_r;
            pw_r <= pw_r + mw_r;
          end
          mr_r    <= mr_r << 1;
          mw_r    <= mw_r << 1;
          ratio_r <= ratio_r >> 1;
          step_r  <= step_r + 3'd1;
          if (step_r == 3'd7) begin
            state_r <= S_CLASS;
          end
        end
        S_CLASS: begin
          mode_r   <= mode_nxt;
          ocnt_r_r <= rd_ext[OUT_COUNT_W-1:0];
          ocnt_w_r <= wd_ext[OUT_COUNT_W-1:0];
          oor_r    <= 1'b0;
          state_r  <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign q_pop            = (state_r == S_IDLE) && q_valid;
  assign clear_done       = (state_r != S_CLEAR);
  assign out_valid        = (state_r == S_OUT);
  assign out_mode         = mode_r;
  assign out_read_count   = ocnt_r_r;
  assign out_write_count  = ocnt_w_r;
  assign out_out_of_range = oor_r;

endmodule

@@ design/chunk_io_heat_classifier.sv @@
// Top level of the chunk I/O heat classifier.
//
//  Channel  Direction  Handshake           Payload
//  in_      input      in_valid/in_stall   in_func, in_sector, in_is_write
//  out_     output     out_valid/out_stall out_mode, out_read_count,
//                                          out_write_count, out_out_of_range
//  cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// An account passes through the back-end steps queue pop, memory read and
// write back; a query passes through pop, read, load, 8 shift-add steps of
// the ratio multiplier and classify, and then holds its result while
// out_stall is high. An out-of-range account is dropped in its pop cycle; an
// out-of-range query goes from the pop cycle straight to the output. After
// reset a clearing pass zeroes both counter memories; in_stall is high
// meanwhile. A two-entry queue keeps accepting items while a result waits
// on out_stall, until the queue is full.
module chunk_io_heat_classifier
  import chc_pkg::*;
#(
  parameter int MAX_CHUNKS  = 1024,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_func,
  input  logic [SECTOR_W-1:0]    in_sector,
  input  logic                   in_is_write,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [MODE_W-1:0]      out_mode,
  output logic [OUT_COUNT_W-1:0] out_read_count,
  output logic [OUT_COUNT_W-1:0] out_write_count,
  output logic                   out_out_of_range,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int QW    = $bits(qctl_t) + IDX_W;

  logic             push;
  qctl_t            push_ctl;
  logic [IDX_W-1:0] push_idx;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic [QW-1:0]    q_dout;
  qctl_t            q_ctl;
  logic [IDX_W-1:0] q_idx;
  logic             clear_done;
  cfg_regs_t        cfg;

  chc_front #(
    .MAX_CHUNKS (MAX_CHUNKS),
    .IDX_W      (IDX_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_func     (in_func),
    .in_sector   (in_sector),
    .in_is_write (in_is_write),
    .in_stall    (in_stall),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cfg_ready   (cfg_ready),
    .q_full      (q_full),
    .clear_done  (clear_done),
    .push        (push),
    .push_ctl    (push_ctl),
    .push_idx    (push_idx),
    .cfg         (cfg)
  );

  chc_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       ({push_ctl, push_idx}),
    .pop       (q_pop),
    .dout      (q_dout),
    .full      (q_full),
    .not_empty (q_valid)
  );

  assign q_ctl = q_dout[QW-1:IDX_W];
  assign q_idx = q_dout[IDX_W-1:0];

  chc_back #(
    .MAX_CHUNKS  (MAX_CHUNKS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .IDX_W       (IDX_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_ctl            (q_ctl),
    .q_idx            (q_idx),
    .q_pop            (q_pop),
    .cfg              (cfg),
    .clear_done       (clear_done),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mode         (out_mode),
    .out_read_count   (out_read_count),
    .out_write_count  (out_write_count),
    .out_out_of_range (out_out_of_range)
  );

endmodule

@@ design/chc_checker.sv @@
// Port-level checker for the chunk I/O heat classifier and its bind.
module chc_checker
  import chc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [MODE_W-1:0]      out_mode,
  input logic [OUT_COUNT_W-1:0] out_read_count,
  input logic [OUT_COUNT_W-1:0] out_write_count,
  input logic                   out_out_of_range
);

  // Reset drops any pending result
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The clearing pass blocks input right after reset
  a_reset_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input accepted during clearing pass");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mode) &&
      $stable(out_read_count) && $stable(out_write_count) &&
      $stable(out_out_of_range))
    else $error("stalled result changed");

  // Out-of-range results carry both-cold and zero counts
  a_oor_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_mode == MODE_BOTH_COLD &&
      out_read_count == '0 && out_write_count == '0)
    else $error("out-of-range result has wrong fields");

endmodule

bind chunk_io_heat_classifier chc_checker u_chc_checker (.*);
